@@ src/keypad_joystick_scanner_assert.svh @@
// assertion macros shared by the scanner rtl
`ifndef KEYPAD_JOYSTICK_SCANNER_ASSERT_SVH
`define KEYPAD_JOYSTICK_SCANNER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked outside reset
`define KJS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked outside reset
`define KJS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KJS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define KJS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ src/kjs_pkg.sv @@
`timescale 1ns / 1ps
package kjs_pkg;

    // moving average geometry
    localparam int AVG_LENGTH = 32;

    function automatic int f_floor_log2(input int n);
        int s;
        int v;
        s = 0;
        v = n;
        while (v > 1) begin
            v = v >> 1;
            s = s + 1;
        end
        return s;
    endfunction

    localparam int SAMPLE_W  = 12;
    localparam int AVG_SHIFT = f_floor_log2(AVG_LENGTH);
    localparam int POS_W     = $clog2(AVG_LENGTH);
    localparam int SUM_W     = SAMPLE_W + $clog2(AVG_LENGTH);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = 12'hFFC;
    localparam logic [SAMPLE_W-1:0] AVG_TOP     = 12'hFFF;

    // key codes
    localparam int CODE_W = 5;
    localparam logic [CODE_W-1:0] CODE_NONE  = 5'd0;
    localparam logic [CODE_W-1:0] CODE_ENTER = 5'd17;
    localparam logic [CODE_W-1:0] CODE_UP    = 5'd18;
    localparam logic [CODE_W-1:0] CODE_DOWN  = 5'd19;
    localparam logic [CODE_W-1:0] CODE_LEFT  = 5'd20;
    localparam logic [CODE_W-1:0] CODE_RIGHT = 5'd21;

    // direction flag bits
    localparam int DIR_UP    = 0;
    localparam int DIR_DOWN  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;

    localparam logic [15:0] CNT_TOP = 16'hFFFF;

    // reset values of the configuration registers
    localparam logic [11:0] HIGH_THR_RST  = 12'd3000;
    localparam logic [11:0] LOW_THR_RST   = 12'd1000;
    localparam logic [15:0] ENTER_LIM_RST = 16'd20;
    localparam logic [15:0] JOY_LIM_RST   = 16'd1000;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_HIGH_THR  = 2'd0,
        CFG_LOW_THR   = 2'd1,
        CFG_ENTER_LIM = 2'd2,
        CFG_JOY_LIM   = 2'd3
    } t_cfg_idx;

    // key tracker status for one tick
    typedef struct packed {
        logic [CODE_W-1:0] first_key;
        logic [CODE_W-1:0] second_key;
        logic [15:0]       keypad_flags;
        logic              enter_held;
        logic              joy_button_held;
        logic [3:0]        direction_flags;
        logic [3:0]        column_drive;
        logic              any_pressed;
    } t_key_status;

endpackage

@@ src/kjs_avg.sv @@
`timescale 1ns / 1ps
module kjs_avg
    import kjs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [POS_W-1:0]    i_wr_pos,
    input  logic [POS_W-1:0]    i_rd_pos,
    input  logic                i_wrapped,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic [SAMPLE_W-1:0] o_avg,
    output logic [SAMPLE_W-1:0] o_avg_next
);

    localparam int QW = SUM_W - AVG_SHIFT;
    localparam logic [QW-1:0] QTOP = QW'(AVG_TOP);

    logic [SAMPLE_W-1:0] mem [AVG_LENGTH];
    logic [SAMPLE_W-1:0] r_rd;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic [SAMPLE_W-1:0] r_avg;
    logic [SAMPLE_W-1:0] n_avg;
    logic [SAMPLE_W-1:0] w_old;
    logic [SAMPLE_W-1:0] w_new;
    logic [QW-1:0]       w_quot;

    // ring storage, read one slot ahead of use
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_pos] <= w_new;
        end
        r_rd <= mem[i_rd_pos];
    end

    // running sum and saturated average
    always_comb begin
        w_new  = i_sample & SAMPLE_MASK;
        w_old  = i_wrapped ? r_rd : '0;
        n_sum  = r_sum - SUM_W'(w_old) + SUM_W'(w_new);
        w_quot = QW'(n_sum >> AVG_SHIFT);
        n_avg  = (w_quot > QTOP) ? AVG_TOP : SAMPLE_W'(w_quot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_avg <= '0;
        end else if (i_wr_en) begin
            r_sum <= n_sum;
            r_avg <= n_avg;
        end
    end

    assign o_avg      = r_avg;
    assign o_avg_next = i_wr_en ? n_avg : r_avg;

endmodule

@@ src/kjs_keys.sv @@
`timescale 1ns / 1ps
module kjs_keys
    import kjs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [3:0]          i_rows,
    input  logic                i_enter,
    input  logic                i_joyb,
    input  logic [SAMPLE_W-1:0] i_avg_h,
    input  logic [SAMPLE_W-1:0] i_avg_v,
    input  logic [11:0]         i_high_thr,
    input  logic [11:0]         i_low_thr,
    input  logic [15:0]         i_enter_lim,
    input  logic [15:0]         i_joy_lim,
    output t_key_status         o_next
);

    typedef struct packed {
        logic [CODE_W-1:0] first;
        logic [CODE_W-1:0] second;
        logic              flag;
    } t_hold;

    // one press or release against the two held codes
    function automatic t_hold f_level(input t_hold h, input logic closed,
                                      input logic [CODE_W-1:0] code);
        t_hold s;
        s = h;
        if (closed) begin
            if (s.second == CODE_NONE) begin
                s.flag = 1'b1;
                if (s.first == CODE_NONE) begin
                    s.first = code;
                end else if (s.first != code) begin
                    s.second = code;
                end
            end
        end else begin
            s.flag = 1'b0;
            if (s.second == code) begin
                s.second = CODE_NONE;
            end else if (s.first == code) begin
                s.first  = s.second;
                s.second = CODE_NONE;
            end
        end
        return s;
    endfunction

    logic [CODE_W-1:0] r_first;
    logic [CODE_W-1:0] r_second;
    logic [15:0]       r_key_flags;
    logic [3:0]        r_dir_flags;
    logic              r_enter_flag;
    logic              r_joy_flag;
    logic [1:0]        r_col;
    logic [15:0]       r_enter_cnt;
    logic [15:0]       r_joy_cnt;

    logic [CODE_W-1:0] n_first;
    logic [CODE_W-1:0] n_second;
    logic [15:0]       n_key_flags;
    logic [3:0]        n_dir_flags;
    logic              n_enter_flag;
    logic              n_joy_flag;
    logic [1:0]        n_col;
    logic [15:0]       n_enter_cnt;
    logic [15:0]       n_joy_cnt;

    t_hold       w_h;
    logic [1:0]  w_prev_col;
    logic [3:0]  w_key;
    logic        w_v_low;
    logic        w_v_high;
    logic        w_h_low;
    logic        w_h_high;
    logic        w_any;

    // one tick of key tracking, in the fixed order of the scan
    always_comb begin
        w_v_low  = i_avg_v < i_low_thr;
        w_v_high = i_avg_v > i_high_thr;
        w_h_low  = i_avg_h < i_low_thr;
        w_h_high = i_avg_h > i_high_thr;

        n_dir_flags = r_dir_flags;
        n_key_flags = r_key_flags;
        w_h = '{first: r_first, second: r_second, flag: r_dir_flags[DIR_DOWN]};

        // joystick deflections
        w_h = f_level(w_h, w_v_low, CODE_DOWN);
        n_dir_flags[DIR_DOWN] = w_h.flag;
        w_h.flag = n_dir_flags[DIR_UP];
        w_h = f_level(w_h, w_v_high, CODE_UP);
        n_dir_flags[DIR_UP] = w_h.flag;
        w_h.flag = n_dir_flags[DIR_RIGHT];
        w_h = f_level(w_h, w_h_high, CODE_RIGHT);
        n_dir_flags[DIR_RIGHT] = w_h.flag;
        w_h.flag = n_dir_flags[DIR_LEFT];
        w_h = f_level(w_h, w_h_low, CODE_LEFT);
        n_dir_flags[DIR_LEFT] = w_h.flag;

        // rows belong to the column driven on the previous tick
        w_prev_col = r_col - 2'd1;
        w_key      = '0;
        for (int r = 0; r < 4; r++) begin
            w_key    = {2'(r), w_prev_col};
            w_h.flag = n_key_flags[w_key];
            w_h      = f_level(w_h, i_rows[r], CODE_W'(w_key) + CODE_W'(1));
            n_key_flags[w_key] = w_h.flag;
        end
        n_col = r_col + 2'd1;

        // enter debounce by count
        w_h.flag     = r_enter_flag;
        n_enter_cnt  = r_enter_cnt;
        if (i_enter) begin
            if (r_enter_cnt > i_enter_lim) begin
                n_enter_cnt = '0;
                w_h = f_level(w_h, 1'b1, CODE_ENTER);
            end else if (r_enter_cnt != CNT_TOP) begin
                n_enter_cnt = r_enter_cnt + 16'd1;
            end
        end else begin
            n_enter_cnt = '0;
            w_h = f_level(w_h, 1'b0, CODE_ENTER);
        end
        n_enter_flag = w_h.flag;

        // joystick button hold time
        n_joy_flag = r_joy_flag;
        n_joy_cnt  = r_joy_cnt;
        if (i_joyb) begin
            if (r_joy_cnt > i_joy_lim) begin
                n_joy_cnt  = '0;
                n_joy_flag = 1'b1;
            end else if (r_joy_cnt != CNT_TOP) begin
                n_joy_cnt = r_joy_cnt + 16'd1;
            end
        end else begin
            n_joy_flag = 1'b0;
            n_joy_cnt  = '0;
        end

        // no held key, enter or stick deflection clears both tracked keys
        w_any = (n_key_flags != '0) || n_enter_flag ||
                w_v_high || w_v_low || w_h_high || w_h_low;
        n_first  = w_any ? w_h.first  : CODE_NONE;
        n_second = w_any ? w_h.second : CODE_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first      <= CODE_NONE;
            r_second     <= CODE_NONE;
            r_key_flags  <= '0;
            r_dir_flags  <= '0;
            r_enter_flag <= 1'b0;
            r_joy_flag   <= 1'b0;
            r_col        <= '0;
            r_enter_cnt  <= '0;
            r_joy_cnt    <= '0;
        end else if (i_step) begin
            r_first      <= n_first;
            r_second     <= n_second;
            r_key_flags  <= n_key_flags;
            r_dir_flags  <= n_dir_flags;
            r_enter_flag <= n_enter_flag;
            r_joy_flag   <= n_joy_flag;
            r_col        <= n_col;
            r_enter_cnt  <= n_enter_cnt;
            r_joy_cnt    <= n_joy_cnt;
        end
    end

    // status of this tick for the result word
    always_comb begin
        o_next.first_key       = n_first;
        o_next.second_key      = n_second;
        o_next.keypad_flags    = n_key_flags;
        o_next.enter_held      = n_enter_flag;
        o_next.joy_button_held = n_joy_flag;
        o_next.direction_flags = n_dir_flags;
        o_next.column_drive    = ~(4'd1 << r_col);
        o_next.any_pressed     = w_any;
    end

endmodule

@@ src/keypad_joystick_scanner.sv @@
`timescale 1ns / 1ps
// Scanner for a 4x4 key matrix, an enter key, a joystick push button and a
// two-axis analog joystick. Each input word is one millisecond tick and gives
// exactly one result word: the tracked first and second keys, all key and
// direction flags, the column to drive for this tick, the two 32-sample
// moving averages and an any-pressed flag. An accepted word is held in the
// input register while the key tracker and the averagers compute the tick,
// then lands in the result register. One word per cycle is sustained while
// the result side is ready, bounded by the combinational key tracking chain
// that feeds back into its own state. The averaging rings start empty after
// reset without any clearing pass, so words are taken from the first cycle
// after reset. Configuration writes are meant for idle periods only.
`include "keypad_joystick_scanner_assert.svh"
module keypad_joystick_scanner
    import kjs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // tick stream in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // row_levels[3:0], enter_level[4], joy_button_level[5], sample_h[17:6],
    // sample_v[29:18], zero [31:30]
    input  logic [31:0] i_s_axis_tdata,
    // adc_ready[0]
    input  logic        i_s_axis_tuser,
    // result stream out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // which_key[4:0], first_key[9:5], second_key[14:10], keypad_flags[30:15],
    // enter_held[31], joy_button_held[32], direction_flags[36:33],
    // column_drive[40:37], average_h[52:41], average_v[64:53],
    // any_pressed[65], zero [71:66]
    output logic [71:0] o_m_axis_tdata
);

    // configuration registers
    logic [11:0] r_high_thr;
    logic [11:0] r_low_thr;
    logic [15:0] r_enter_lim;
    logic [15:0] r_joy_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thr  <= HIGH_THR_RST;
            r_low_thr   <= LOW_THR_RST;
            r_enter_lim <= ENTER_LIM_RST;
            r_joy_lim   <= JOY_LIM_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HIGH_THR:  r_high_thr  <= i_cfg_data[11:0];
                CFG_LOW_THR:   r_low_thr   <= i_cfg_data[11:0];
                CFG_ENTER_LIM: r_enter_lim <= i_cfg_data;
                CFG_JOY_LIM:   r_joy_lim   <= i_cfg_data;
            endcase
        end
    end

    // input register
    logic                r_in_valid;
    logic [3:0]          r_in_rows;
    logic                r_in_enter;
    logic                r_in_joyb;
    logic                r_in_ready;
    logic [SAMPLE_W-1:0] r_in_sh;
    logic [SAMPLE_W-1:0] r_in_sv;
    logic                r_out_valid;
    logic [71:0]         r_out_data;
    logic                w_step;
    logic                w_in_take;

    assign w_step          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_step;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_rows  <= i_s_axis_tdata[3:0];
            r_in_enter <= i_s_axis_tdata[4];
            r_in_joyb  <= i_s_axis_tdata[5];
            r_in_sh    <= i_s_axis_tdata[17:6];
            r_in_sv    <= i_s_axis_tdata[29:18];
            r_in_ready <= i_s_axis_tuser;
        end
    end

    // ring position shared by both axes
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             r_wrapped;
    logic             n_wrapped;
    logic             w_avg_we;

    assign w_avg_we = w_step && r_in_ready;

    always_comb begin
        n_pos     = r_pos;
        n_wrapped = r_wrapped;
        if (!i_rst_n) begin
            n_pos     = '0;
            n_wrapped = 1'b0;
        end else if (w_avg_we) begin
            if (r_pos == POS_W'(AVG_LENGTH - 1)) begin
                n_pos     = '0;
                n_wrapped = 1'b1;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_wrapped <= n_wrapped;
    end

    // averagers
    logic [SAMPLE_W-1:0] w_avg_h;
    logic [SAMPLE_W-1:0] w_avg_v;
    logic [SAMPLE_W-1:0] w_avg_h_next;
    logic [SAMPLE_W-1:0] w_avg_v_next;

    kjs_avg u_avg_h (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_avg_we),
        .i_wr_pos   (r_pos),
        .i_rd_pos   (n_pos),
        .i_wrapped  (r_wrapped),
        .i_sample   (r_in_sh),
        .o_avg      (w_avg_h),
        .o_avg_next (w_avg_h_next)
    );

    kjs_avg u_avg_v (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_avg_we),
        .i_wr_pos   (r_pos),
        .i_rd_pos   (n_pos),
        .i_wrapped  (r_wrapped),
        .i_sample   (r_in_sv),
        .o_avg      (w_avg_v),
        .o_avg_next (w_avg_v_next)
    );

    // key tracker
    t_key_status w_keys;

    kjs_keys u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_rows      (r_in_rows),
        .i_enter     (r_in_enter),
        .i_joyb      (r_in_joyb),
        .i_avg_h     (w_avg_h),
        .i_avg_v     (w_avg_v),
        .i_high_thr  (r_high_thr),
        .i_low_thr   (r_low_thr),
        .i_enter_lim (r_enter_lim),
        .i_joy_lim   (r_joy_lim),
        .o_next      (w_keys)
    );

    // result word
    logic [CODE_W-1:0] w_which;
    logic [71:0]       n_out_data;

    assign w_which = (w_keys.second_key != CODE_NONE) ? w_keys.second_key
                                                      : w_keys.first_key;
    assign n_out_data = {6'd0, w_keys.any_pressed, w_avg_v_next, w_avg_h_next,
                         w_keys.column_drive, w_keys.direction_flags,
                         w_keys.joy_button_held, w_keys.enter_held,
                         w_keys.keypad_flags, w_keys.second_key,
                         w_keys.first_key, w_which};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // checks
    `KJS_ASSERT_IMP(a_col_onehot, i_clk, i_rst_n, r_out_valid,
        $onehot(~r_out_data[40:37]), "column drive is not one-hot active low")
    `KJS_ASSERT_IMP(a_second_needs_first, i_clk, i_rst_n, r_out_valid,
        (r_out_data[14:10] == CODE_NONE) || (r_out_data[9:5] != CODE_NONE),
        "second key held without a first key")
    `KJS_ASSERT_NXT(a_step_gives_word, i_clk, i_rst_n, w_step,
        r_out_valid, "processed tick produced no result word")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import kjs_pkg::*;

    // cycles without any handshake or register write before the run is called hung
    localparam int QUIET_LIMIT = 1000;

    // one millisecond tick as the sender sees it
    typedef struct packed {
        logic        ready;
        logic [11:0] sample_v;
        logic [11:0] sample_h;
        logic        joy;
        logic        enter;
        logic [3:0]  rows;
    } t_tick;

    // result word, laid out to match o_m_axis_tdata bit for bit
    typedef struct packed {
        logic [5:0]  pad;
        logic        any_pressed;
        logic [11:0] average_v;
        logic [11:0] average_h;
        logic [3:0]  column_drive;
        logic [3:0]  direction_flags;
        logic        joy_button_held;
        logic        enter_held;
        logic [15:0] keypad_flags;
        logic [4:0]  second_key;
        logic [4:0]  first_key;
        logic [4:0]  which_key;
    } t_scan_word;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    t_cfg_idx    i_cfg_index     = CFG_HIGH_THR;
    logic [15:0] i_cfg_data      = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [31:0] i_s_axis_tdata  = '0;
    logic        i_s_axis_tuser  = 1'b0;
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [71:0] o_m_axis_tdata;

    keypad_joystick_scanner i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // scanner state as predicted from the accepted ticks
    logic [11:0]      thr_hi, thr_lo;
    logic [15:0]      enter_lim, joy_lim;
    logic [4:0]       first_held, second_held;
    logic [15:0]      key_flags;
    logic [3:0]       dir_flags;
    logic             enter_flag, joy_flag;
    logic [1:0]       col_idx;
    logic [15:0]      enter_cnt, joy_cnt;
    logic [11:0]      ring_h [AVG_LENGTH];
    logic [11:0]      ring_v [AVG_LENGTH];
    logic [SUM_W-1:0] sum_h, sum_v;
    logic [POS_W-1:0] ring_pos;
    logic [11:0]      avg_h, avg_v;

    t_scan_word expected_words[$];
    t_scan_word exp_word;
    int         err_count   = 0;
    int         quiet_count = 0;

    task automatic clear_model();
        thr_hi      = HIGH_THR_RST;
        thr_lo      = LOW_THR_RST;
        enter_lim   = ENTER_LIM_RST;
        joy_lim     = JOY_LIM_RST;
        first_held  = CODE_NONE;
        second_held = CODE_NONE;
        key_flags   = '0;
        dir_flags   = '0;
        enter_flag  = 1'b0;
        joy_flag    = 1'b0;
        col_idx     = '0;
        enter_cnt   = '0;
        joy_cnt     = '0;
        for (int i = 0; i < AVG_LENGTH; i++) begin
            ring_h[i] = '0;
            ring_v[i] = '0;
        end
        sum_h    = '0;
        sum_v    = '0;
        ring_pos = '0;
        avg_h    = '0;
        avg_v    = '0;
    endtask

    // press or release of one code against the two tracked keys
    task automatic key_level(input logic closed, input logic [4:0] code,
                             inout logic flag);
        if (closed) begin
            if (second_held == CODE_NONE) begin
                flag = 1'b1;
                if (first_held == CODE_NONE) begin
                    first_held = code;
                end else if (first_held != code) begin
                    second_held = code;
                end
            end
        end else begin
            flag = 1'b0;
            if (second_held == code) begin
                second_held = CODE_NONE;
            end else if (first_held == code) begin
                first_held  = second_held;
                second_held = CODE_NONE;
            end
        end
    endtask

    // one tick through the predictor
    task automatic predict(input t_tick tk, output t_scan_word w);
        logic [1:0]  c;
        logic        f;
        logic        any_hit;
        logic [3:0]  drive;
        logic [11:0] s_h;
        logic [11:0] s_v;
        int          k;
        int          a;
        c = col_idx;

        // joystick deflections from the stored averages
        f = dir_flags[DIR_DOWN];
        key_level(avg_v < thr_lo, CODE_DOWN, f);
        dir_flags[DIR_DOWN] = f;
        f = dir_flags[DIR_UP];
        key_level(avg_v > thr_hi, CODE_UP, f);
        dir_flags[DIR_UP] = f;
        f = dir_flags[DIR_RIGHT];
        key_level(avg_h > thr_hi, CODE_RIGHT, f);
        dir_flags[DIR_RIGHT] = f;
        f = dir_flags[DIR_LEFT];
        key_level(avg_h < thr_lo, CODE_LEFT, f);
        dir_flags[DIR_LEFT] = f;

        // rows of the column driven on the previous tick
        for (int r = 0; r < 4; r++) begin
            k = 4 * r + ((int'(c) + 3) % 4);
            f = key_flags[k];
            key_level(tk.rows[r], 5'(k + 1), f);
            key_flags[k] = f;
        end
        drive   = 4'hF & ~(4'd1 << c);
        col_idx = c + 2'd1;

        // enter debounce
        if (tk.enter) begin
            if (enter_cnt > enter_lim) begin
                enter_cnt = '0;
                f = enter_flag;
                key_level(1'b1, CODE_ENTER, f);
                enter_flag = f;
            end else if (enter_cnt != 16'hFFFF) begin
                enter_cnt = enter_cnt + 16'd1;
            end
        end else begin
            enter_cnt = '0;
            f = enter_flag;
            key_level(1'b0, CODE_ENTER, f);
            enter_flag = f;
        end

        // joystick button hold
        if (tk.joy) begin
            if (joy_cnt > joy_lim) begin
                joy_cnt  = '0;
                joy_flag = 1'b1;
            end else if (joy_cnt != 16'hFFFF) begin
                joy_cnt = joy_cnt + 16'd1;
            end
        end else begin
            joy_flag = 1'b0;
            joy_cnt  = '0;
        end

        any_hit = (key_flags != '0) || enter_flag ||
                  (avg_v > thr_hi) || (avg_v < thr_lo) ||
                  (avg_h > thr_hi) || (avg_h < thr_lo);
        if (!any_hit) begin
            first_held  = CODE_NONE;
            second_held = CODE_NONE;
        end

        // moving averages
        if (tk.ready) begin
            s_h   = tk.sample_h & SAMPLE_MASK;
            s_v   = tk.sample_v & SAMPLE_MASK;
            sum_h = sum_h - SUM_W'(ring_h[ring_pos]) + SUM_W'(s_h);
            sum_v = sum_v - SUM_W'(ring_v[ring_pos]) + SUM_W'(s_v);
            ring_h[ring_pos] = s_h;
            ring_v[ring_pos] = s_v;
            a     = int'(sum_h) >> AVG_SHIFT;
            avg_h = (a > 4095) ? 12'hFFF : 12'(a);
            a     = int'(sum_v) >> AVG_SHIFT;
            avg_v = (a > 4095) ? 12'hFFF : 12'(a);
            ring_pos = (ring_pos == POS_W'(AVG_LENGTH - 1)) ? '0 : ring_pos + POS_W'(1);
        end

        w.pad             = '0;
        w.any_pressed     = any_hit;
        w.average_v       = avg_v;
        w.average_h       = avg_h;
        w.column_drive    = drive;
        w.direction_flags = dir_flags;
        w.joy_button_held = joy_flag;
        w.enter_held      = enter_flag;
        w.keypad_flags    = key_flags;
        w.second_key      = second_held;
        w.first_key       = first_held;
        w.which_key       = (second_held != CODE_NONE) ? second_held : first_held;
    endtask

    function automatic t_tick make_tick(input logic [3:0] rows, input logic enter,
                                        input logic joy, input logic ready,
                                        input logic [11:0] s_h, input logic [11:0] s_v);
        t_tick tk;
        tk.rows     = rows;
        tk.enter    = enter;
        tk.joy      = joy;
        tk.ready    = ready;
        tk.sample_h = s_h;
        tk.sample_v = s_v;
        return tk;
    endfunction

    // send one word and predict its result at the accepting edge
    task automatic send_tick(input t_tick tk);
        int         gap;
        t_scan_word w;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, tk.sample_v, tk.sample_h, tk.joy, tk.enter, tk.rows};
        i_s_axis_tuser  <= tk.ready;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        predict(tk, w);
        expected_words.push_back(w);
    endtask

    // stop sending until every expected word has come back
    task automatic wait_drain();
        i_s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_words.size() != 0);
    endtask

    // register write while the scanner is idle
    task automatic write_cfg(input t_cfg_idx idx, input logic [15:0] wdata);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= wdata;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        unique case (idx)
            CFG_HIGH_THR:  thr_hi    = wdata[11:0];
            CFG_LOW_THR:   thr_lo    = wdata[11:0];
            CFG_ENTER_LIM: enter_lim = wdata;
            CFG_JOY_LIM:   joy_lim   = wdata;
        endcase
    endtask

    function automatic logic [11:0] center_sample();
        return 12'(2048 + $urandom_range(0, 63));
    endfunction

    // column rotation with the averages still at zero
    task automatic test_idle_scan();
        for (int i = 0; i < 20; i++) begin
            send_tick(make_tick(4'h0, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0));
        end
    endtask

    // averages climb to the middle and release the deflections
    task automatic test_center_stick();
        for (int i = 0; i < 60; i++) begin
            send_tick(make_tick(4'h0, 1'b0, 1'b0, 1'b1, center_sample(), center_sample()));
        end
    endtask

    // key matrix with one and more keys held
    task automatic test_keypad_matrix();
        logic [3:0] rows;
        rows = '0;
        for (int i = 0; i < 120; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                rows = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 15)) : 4'h0;
            end
            send_tick(make_tick(rows, 1'b0, 1'b0, 1'b1, center_sample(), center_sample()));
        end
    endtask

    // enter counted past a short limit and a zero limit
    task automatic test_enter_debounce();
        wait_drain();
        write_cfg(CFG_ENTER_LIM, 16'd3);
        for (int i = 0; i < 15; i++) begin
            send_tick(make_tick(4'h0, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0));
        end
        for (int i = 0; i < 5; i++) begin
            send_tick(make_tick(4'h1, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0));
        end
        wait_drain();
        write_cfg(CFG_ENTER_LIM, 16'd0);
        for (int i = 0; i < 10; i++) begin
            send_tick(make_tick(4'h2, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0));
        end
        for (int i = 0; i < 10; i++) begin
            send_tick(make_tick(4'h0, 1'(i % 2), 1'b0, 1'b0, 12'd0, 12'd0));
        end
    endtask

    // joystick button held past its limit
    task automatic test_joy_hold();
        wait_drain();
        write_cfg(CFG_JOY_LIM, 16'd5);
        for (int i = 0; i < 20; i++) begin
            send_tick(make_tick(4'h0, 1'b0, 1'b1, 1'b0, 12'd0, 12'd0));
        end
        for (int i = 0; i < 5; i++) begin
            send_tick(make_tick(4'h0, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0));
        end
        for (int i = 0; i < 15; i++) begin
            send_tick(make_tick(4'h0, 1'b0, ($urandom_range(0, 3) != 0), 1'b0,
                                12'd0, 12'd0));
        end
    endtask

    // averages driven to both ends across new thresholds
    task automatic test_thresholds();
        wait_drain();
        write_cfg(CFG_HIGH_THR, 16'd3500);
        write_cfg(CFG_LOW_THR, 16'd500);
        for (int i = 0; i < 40; i++) begin
            send_tick(make_tick(($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'h0,
                                1'b0, 1'b0, 1'b1, 12'hFFF, 12'h000));
        end
        for (int i = 0; i < 40; i++) begin
            send_tick(make_tick(($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'h0,
                                1'b0, 1'b0, 1'b1, 12'h000, 12'hFFF));
        end
    endtask

    // everything random under random settings
    task automatic test_random_mix();
        wait_drain();
        write_cfg(CFG_HIGH_THR, 16'(2048 + $urandom_range(0, 2047)));
        write_cfg(CFG_LOW_THR, 16'($urandom_range(0, 2047)));
        write_cfg(CFG_ENTER_LIM, 16'($urandom_range(0, 8)));
        write_cfg(CFG_JOY_LIM, 16'($urandom_range(0, 8)));
        for (int i = 0; i < 100; i++) begin
            send_tick(make_tick(4'($urandom_range(0, 15)), ($urandom_range(0, 3) != 0),
                                ($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)),
                                12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095))));
        end
    endtask

    // result side ready with random pauses
    initial begin : sink
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = $urandom_range(0, 3);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!o_m_axis_tvalid);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h",
                         $time, o_m_axis_tdata);
                err_count++;
            end else begin
                exp_word = expected_words.pop_front();
                if (o_m_axis_tdata !== exp_word) begin
                    $display("%0t: word mismatch, expected %h, actual %h",
                             $time, exp_word, o_m_axis_tdata);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || i_cfg_we) begin
            quiet_count = 0;
        end else begin
            quiet_count = quiet_count + 1;
            if (quiet_count >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        clear_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_scan();
        test_center_stick();
        test_keypad_matrix();
        test_enter_debounce();
        test_joy_hold();
        test_thresholds();
        test_random_mix();
        wait_drain();
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && expected_words.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
